[src/rbb_pkg.sv]
`default_nettype none

package rbb_pkg;

  // Field and register widths
  localparam int unsigned ColorW = 8;
  localparam int unsigned CoordW = 11;
  localparam int unsigned DimW   = 12;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned PauseW = 5;
  localparam int unsigned SumW   = 28;
  localparam int unsigned ProdW  = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  // Largest usable frame dimension
  localparam logic [DimW-1:0] MaxDim = DimW'(2048);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DUTY_LOW     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DUTY_MEDIUM  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DUTY_HIGH    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PAUSE_LONG   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_PAUSE_SHORT  = 3'd6;

  // Register reset values
  localparam logic [DimW-1:0]   RstFrameWidth  = 12'd640;
  localparam logic [DimW-1:0]   RstFrameHeight = 12'd480;
  localparam logic [DutyW-1:0]  RstDutyLow     = 8'd64;
  localparam logic [DutyW-1:0]  RstDutyMedium  = 8'd128;
  localparam logic [DutyW-1:0]  RstDutyHigh    = 8'd192;
  localparam logic [PauseW-1:0] RstPauseLong   = 5'd20;
  localparam logic [PauseW-1:0] RstPauseShort  = 5'd15;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    PH_FORWARD = 2'd0,
    PH_RIGHT   = 2'd1,
    PH_LEFT    = 2'd2
  } phase_e;

  typedef struct packed {
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic              frame_end;
  } pixel_t;

  typedef struct packed {
    logic [DutyW-1:0] left_duty;
    dir_e             left_dir;
    logic [DutyW-1:0] right_duty;
    dir_e             right_dir;
    logic             blob_seen;
    logic             decided;
  } result_t;

  typedef struct packed {
    logic [DutyW-1:0] left_duty;
    dir_e             left_dir;
    logic [DutyW-1:0] right_duty;
    dir_e             right_dir;
  } cmd_t;

  typedef struct packed {
    logic [SumW-1:0] sum_blue;
    logic [SumW-1:0] sum_green;
    logic [SumW-1:0] sum_red;
  } summary_t;

  typedef struct packed {
    logic [DimW-1:0]   frame_width;
    logic [DimW-1:0]   frame_height;
    logic [DutyW-1:0]  duty_low;
    logic [DutyW-1:0]  duty_medium;
    logic [DutyW-1:0]  duty_high;
    logic [PauseW-1:0] pause_long;
    logic [PauseW-1:0] pause_short;
  } cfg_t;

  // Saturating accumulate of one color sample
  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] s,
                                              input logic [ColorW-1:0] v);
    logic [SumW:0] t;
    t = {1'b0, s} + {{(SumW+1-ColorW){1'b0}}, v};
    return t[SumW] ? {SumW{1'b1}} : t[SumW-1:0];
  endfunction

endpackage

`default_nettype wire

[src/rbb_front.sv]
`default_nettype none

module rbb_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rbb_pkg::cfg_t   cfg_i,
  input  wire logic            accept_i,
  input  wire rbb_pkg::pixel_t pixel_i,
  output logic                 sum_push_o,
  output rbb_pkg::summary_t    sum_o
);

  logic [rbb_pkg::DimW-1:0]   w, h, row_lo, col_lo, col_hi;
  logic [rbb_pkg::DimW+1:0]   w3;
  logic [rbb_pkg::DimW-1:0]   row_x, col_x;
  logic                       in_win;
  rbb_pkg::summary_t          acc_q, acc_d, upd;

  // Clamp dimensions and derive window bounds
  always_comb begin
    w = (cfg_i.frame_width > rbb_pkg::MaxDim) ? rbb_pkg::MaxDim : cfg_i.frame_width;
    h = (cfg_i.frame_height > rbb_pkg::MaxDim) ? rbb_pkg::MaxDim : cfg_i.frame_height;
    row_lo = {1'b0, h[rbb_pkg::DimW-1:1]};
    col_lo = {2'b00, w[rbb_pkg::DimW-1:2]};
    w3 = {2'b00, w} + {1'b0, w, 1'b0};
    col_hi = w3[rbb_pkg::DimW+1:2];
    row_x = {1'b0, pixel_i.row};
    col_x = {1'b0, pixel_i.col};
    in_win = (row_x >= row_lo) && (row_x < h) && (col_x >= col_lo) && (col_x < col_hi);
  end

  // Accumulate window pixels; hand off and clear at end of frame
  always_comb begin
    upd = acc_q;
    if (in_win) begin
      upd.sum_blue  = rbb_pkg::sat_add(acc_q.sum_blue, pixel_i.blue);
      upd.sum_green = rbb_pkg::sat_add(acc_q.sum_green, pixel_i.green);
      upd.sum_red   = rbb_pkg::sat_add(acc_q.sum_red, pixel_i.red);
    end
    acc_d = acc_q;
    if (accept_i) begin
      acc_d = pixel_i.frame_end ? '0 : upd;
    end
  end

  assign sum_push_o = accept_i && pixel_i.frame_end;
  assign sum_o      = upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

`default_nettype wire

[src/rbb_sumq.sv]
`default_nettype none

module rbb_sumq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire rbb_pkg::summary_t data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output rbb_pkg::summary_t      data_o
);

  rbb_pkg::summary_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[src/rbb_back.sv]
`default_nettype none

module rbb_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rbb_pkg::cfg_t     cfg_i,
  input  wire logic              sum_empty_i,
  input  wire rbb_pkg::summary_t sum_i,
  output logic                   sum_pop_o,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output rbb_pkg::result_t       result_o
);

  logic [rbb_pkg::PauseW-1:0] pause_q, pause_d;
  rbb_pkg::phase_e            phase_q, phase_d;
  rbb_pkg::cmd_t              held_q, held_d;
  logic [rbb_pkg::ProdW-1:0]  b10, r11, g11;
  logic                       blob, decided;
  rbb_pkg::result_t           res;
  rbb_pkg::result_t           oq_q [2];
  logic                       wr_ptr_q, rd_ptr_q;
  logic [1:0]                 cnt_q, cnt_d;
  logic                       do_pop;

  // Take a summary when the result queue has room
  assign do_pop    = !sum_empty_i && (cnt_q != 2'd2);
  assign sum_pop_o = do_pop;

  // Scaled color comparison by shift and add
  always_comb begin
    b10 = {1'b0, sum_i.sum_blue, 3'b000} + {3'b000, sum_i.sum_blue, 1'b0};
    r11 = {1'b0, sum_i.sum_red, 3'b000} + {3'b000, sum_i.sum_red, 1'b0}
        + {4'b0000, sum_i.sum_red};
    g11 = {1'b0, sum_i.sum_green, 3'b000} + {3'b000, sum_i.sum_green, 1'b0}
        + {4'b0000, sum_i.sum_green};
  end

  // Decide or count down the pause
  always_comb begin
    pause_d = pause_q;
    phase_d = phase_q;
    held_d  = held_q;
    blob    = 1'b0;
    decided = 1'b0;
    if (pause_q != '0) begin
      pause_d = pause_q - rbb_pkg::PauseW'(1);
    end else begin
      decided = 1'b1;
      blob    = (b10 > r11) && (b10 > g11);
      if (!blob) begin
        held_d = '{cfg_i.duty_medium, rbb_pkg::DIR_REV, cfg_i.duty_medium, rbb_pkg::DIR_FWD};
      end else begin
        case (phase_q)
          rbb_pkg::PH_FORWARD: begin
            held_d  = '{cfg_i.duty_medium, rbb_pkg::DIR_FWD,
                        cfg_i.duty_medium, rbb_pkg::DIR_FWD};
            phase_d = rbb_pkg::PH_RIGHT;
            pause_d = cfg_i.pause_long;
          end
          rbb_pkg::PH_RIGHT: begin
            held_d  = '{cfg_i.duty_high, rbb_pkg::DIR_FWD, cfg_i.duty_low, rbb_pkg::DIR_FWD};
            phase_d = rbb_pkg::PH_LEFT;
            pause_d = cfg_i.pause_short;
          end
          rbb_pkg::PH_LEFT: begin
            held_d  = '{cfg_i.duty_low, rbb_pkg::DIR_FWD, cfg_i.duty_high, rbb_pkg::DIR_FWD};
            phase_d = rbb_pkg::PH_FORWARD;
            pause_d = cfg_i.pause_long;
          end
          default: begin
            phase_d = rbb_pkg::PH_FORWARD;
          end
        endcase
      end
    end
    res = '{held_d.left_duty, held_d.left_dir, held_d.right_duty, held_d.right_dir,
            blob, decided};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_q <= '0;
      phase_q <= rbb_pkg::PH_FORWARD;
      held_q  <= '{rbb_pkg::RstDutyLow, rbb_pkg::DIR_STOP,
                   rbb_pkg::RstDutyLow, rbb_pkg::DIR_STOP};
    end else if (do_pop) begin
      pause_q <= pause_d;
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  // Result queue: hold results until popped
  assign empty_o  = (cnt_q == 2'd0);
  assign result_o = oq_q[rd_ptr_q];
  assign cnt_d    = cnt_q + {1'b0, do_pop} - {1'b0, pop_i && !empty_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_pop) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      oq_q[wr_ptr_q] <= res;
    end
  end

endmodule

`default_nettype wire

[src/roi_blue_blob_motor_sequencer.sv]
// A frame_end request's sums are registered in the summary queue, then its result in the result queue.
// Throughput: one pixel request per cycle while the summary queue is not full; one result per frame.
// The pause/phase decision unit takes one frame summary per cycle when the result queue has room.
// Reset (rst_ni low, asynchronous): sums, pause count and phase clear, the held
// command returns to both duties 64 and both motors stopped, registers take defaults.
`default_nettype none

module roi_blue_blob_motor_sequencer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire rbb_pkg::pixel_t                 in_item_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output rbb_pkg::result_t                     out_item_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [rbb_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [rbb_pkg::CfgDataW-1:0]    cfg_data_i
);

  rbb_pkg::cfg_t     cfg_q, cfg_d;
  rbb_pkg::summary_t sum_in, sum_out;
  logic              accept, sum_push, sum_full, sum_empty, sum_pop;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;
  assign full        = sum_full;

  // Decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        rbb_pkg::CFG_FRAME_WIDTH:  cfg_d.frame_width  = cfg_data_i;
        rbb_pkg::CFG_FRAME_HEIGHT: cfg_d.frame_height = cfg_data_i;
        rbb_pkg::CFG_DUTY_LOW:     cfg_d.duty_low     = cfg_data_i[rbb_pkg::DutyW-1:0];
        rbb_pkg::CFG_DUTY_MEDIUM:  cfg_d.duty_medium  = cfg_data_i[rbb_pkg::DutyW-1:0];
        rbb_pkg::CFG_DUTY_HIGH:    cfg_d.duty_high    = cfg_data_i[rbb_pkg::DutyW-1:0];
        rbb_pkg::CFG_PAUSE_LONG:   cfg_d.pause_long   = cfg_data_i[rbb_pkg::PauseW-1:0];
        rbb_pkg::CFG_PAUSE_SHORT:  cfg_d.pause_short  = cfg_data_i[rbb_pkg::PauseW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{rbb_pkg::RstFrameWidth, rbb_pkg::RstFrameHeight, rbb_pkg::RstDutyLow,
                 rbb_pkg::RstDutyMedium, rbb_pkg::RstDutyHigh, rbb_pkg::RstPauseLong,
                 rbb_pkg::RstPauseShort};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rbb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .accept_i   (accept),
    .pixel_i    (in_item_i),
    .sum_push_o (sum_push),
    .sum_o      (sum_in)
  );

  rbb_sumq u_sumq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (sum_push),
    .data_i  (sum_in),
    .full_o  (sum_full),
    .pop_i   (sum_pop),
    .empty_o (sum_empty),
    .data_o  (sum_out)
  );

  rbb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .sum_empty_i (sum_empty),
    .sum_i       (sum_out),
    .sum_pop_o   (sum_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (out_item_o)
  );

endmodule

`default_nettype wire
